@@ rtl/core/tsf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tsf_pkg;

    localparam int ID_W       = 16;
    localparam int BYTE_W     = 8;
    localparam int ROOM_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int QCOUNT_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SLOT_MAX   = 6;
    localparam int HDR_BYTES  = 3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

    localparam logic [STATUS_W-1:0] DROP_NONE   = 3'd0;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 3'd6;

    typedef struct packed {
        logic              operation;
        logic [ID_W-1:0]   stream_id;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic [ROOM_W-1:0] frame_room;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   out_byte;
        logic                record_end;
        logic [QCOUNT_W-1:0] queue_count;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/tsf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tagged_record_stream_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ring queue of tagged records. Push words carry one record byte each and
// last_byte closes the record; the record is committed only at its last byte
// and dropped if its stream is not enabled, the queue is full at its first
// byte, or it runs past MAX_PAYLOAD bytes. Pop words return the head record
// as id low, id high, length, then the data, and the record is released on
// its final byte. The edge that accepts a word also reads the head metadata
// and payload memories; the word then moves to S_EXEC, whose closing edge
// updates the pointers, writes the memories back and loads the result
// register. A new word is accepted while a finished result still waits to
// be taken; a word waits in S_EXEC only while the result register is full
// and stalled. Payload storage is QUEUE_DEPTH x 256 bytes in one RAM, ids
// and lengths in a QUEUE_DEPTH-entry RAM; neither needs clearing after reset.
// Config writes are always taken and must happen while the block is idle.

module tagged_record_stream_fifo #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int MAX_PAYLOAD  = 255,
    parameter int STREAM_SLOTS = 6
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire tsf_pkg::item_t                     item,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output tsf_pkg::result_t                        result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SLOT_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W    = tsf_pkg::BYTE_W;
    localparam int OFF_W    = LEN_W + 1;
    localparam int META_W   = tsf_pkg::ID_W + LEN_W;
    localparam int BYTES_D  = QUEUE_DEPTH * 256;
    localparam int BADDR_W  = $clog2(BYTES_D);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                          state_reg, state_next;
    tsf_pkg::item_t                  item_reg;
    tsf_pkg::result_t                result_reg, result_next;
    logic                            result_valid_reg, result_valid_next;

    logic [tsf_pkg::ID_W-1:0]        cfg_id_reg [tsf_pkg::SLOT_MAX];
    logic [tsf_pkg::SLOT_MAX-1:0]    enable_reg;

    logic [SLOT_W-1:0]               head_reg, head_next;
    logic [SLOT_W-1:0]               tail_reg, tail_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [LEN_W-1:0]                push_len_reg, push_len_next;
    logic [tsf_pkg::STATUS_W-1:0]    drop_reg, drop_next;
    logic [OFF_W-1:0]                pop_off_reg, pop_off_next;
    logic [tsf_pkg::ID_W-1:0]        push_id_reg, push_id_next;

    logic                            accept;
    logic                            exec_fire;
    logic                            slot_hit;
    logic [tsf_pkg::STATUS_W-1:0]    reason;
    logic [CNT_W+6:0]                count_ext;

    logic                            meta_we;
    logic [META_W-1:0]               meta_wdata;
    logic [META_W-1:0]               meta_rdata;
    logic                            byte_we;
    logic [BADDR_W-1:0]              byte_waddr;
    logic [BADDR_W-1:0]              byte_raddr;
    logic [tsf_pkg::BYTE_W-1:0]      byte_rdata;
    logic [OFF_W-1:0]                off_m3;

    logic [tsf_pkg::ID_W-1:0]        head_id;
    logic [LEN_W-1:0]                head_len;
    logic [OFF_W-1:0]                head_len_ext;
    logic [tsf_pkg::ID_W-1:0]        commit_id;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg == S_EXEC);
    assign exec_fire  = (state_reg == S_EXEC) && (!result_valid_reg || !result_stall);
    assign cfg_ready  = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign off_m3     = pop_off_reg - OFF_W'(tsf_pkg::HDR_BYTES);
    assign byte_raddr = {head_reg, off_m3[LEN_W-1:0]};
    assign head_id    = meta_rdata[META_W-1:LEN_W];
    assign head_len   = meta_rdata[LEN_W-1:0];
    assign head_len_ext = {1'b0, head_len};
    assign count_ext  = {7'd0, count_next};

    tsf_ram #(
        .WIDTH (META_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (tail_reg),
        .wdata (meta_wdata),
        .re    (accept),
        .raddr (head_reg),
        .rdata (meta_rdata)
    );

    tsf_ram #(
        .WIDTH (tsf_pkg::BYTE_W),
        .DEPTH (BYTES_D)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (item_reg.data_byte),
        .re    (accept),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    function automatic logic [tsf_pkg::ROOM_W-1:0] ROOM_EXT(input logic [OFF_W-1:0] len);
        logic [OFF_W-1:0] need;
        need = len + OFF_W'(tsf_pkg::HDR_BYTES);
        return tsf_pkg::ROOM_W'(need);
    endfunction

    always_comb
    begin
        slot_hit = 1'b0;
        for (int k = 0; k < STREAM_SLOTS; k++)
        begin
            if (enable_reg[k] && (cfg_id_reg[k] == item_reg.stream_id))
            begin
                slot_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        push_len_next     = push_len_reg;
        drop_next         = drop_reg;
        pop_off_next      = pop_off_reg;
        push_id_next      = push_id_reg;
        reason            = drop_reg;
        commit_id         = push_id_reg;
        meta_we           = 1'b0;
        meta_wdata        = {head_id, head_len};
        byte_we           = 1'b0;
        byte_waddr        = {tail_reg, push_len_reg};

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (accept)
        begin
            state_next = S_EXEC;
        end

        if (exec_fire)
        begin
            state_next             = S_IDLE;
            result_valid_next      = 1'b1;
            result_next.out_byte   = '0;
            result_next.record_end = 1'b0;

            if (item_reg.operation == tsf_pkg::OP_PUSH)
            begin
                if (drop_reg == tsf_pkg::DROP_NONE)
                begin
                    if (push_len_reg == '0)
                    begin
                        if (!slot_hit)
                        begin
                            reason = tsf_pkg::ST_DISABLED;
                        end
                        else if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            reason = tsf_pkg::ST_FULL;
                        end
                        else
                        begin
                            push_id_next = item_reg.stream_id;
                            commit_id    = item_reg.stream_id;
                        end
                    end
                    else if (push_len_reg >= LEN_W'(MAX_PAYLOAD))
                    begin
                        reason = tsf_pkg::ST_TOO_LONG;
                    end
                end

                if (reason != tsf_pkg::DROP_NONE)
                begin
                    result_next.status = reason;
                    if (item_reg.last_byte)
                    begin
                        drop_next     = tsf_pkg::DROP_NONE;
                        push_len_next = '0;
                    end
                    else
                    begin
                        drop_next = reason;
                    end
                end
                else
                begin
                    result_next.status = tsf_pkg::ST_STORED;
                    byte_we            = 1'b1;
                    push_len_next      = push_len_reg + LEN_W'(1);
                    if (item_reg.last_byte)
                    begin
                        meta_we       = 1'b1;
                        meta_wdata    = {commit_id, push_len_reg + LEN_W'(1)};
                        tail_next     = (tail_reg == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                        '0 : tail_reg + SLOT_W'(1);
                        count_next    = count_reg + CNT_W'(1);
                        push_len_next = '0;
                    end
                end
            end
            else
            begin
                if ((count_reg == '0) ||
                    ((pop_off_reg == '0) &&
                     (ROOM_EXT(head_len_ext) > item_reg.frame_room)))
                begin
                    result_next.status = tsf_pkg::ST_EMPTY;
                end
                else
                begin
                    result_next.status = tsf_pkg::ST_OK;
                    case (pop_off_reg)
                        OFF_W'(0): result_next.out_byte = head_id[7:0];
                        OFF_W'(1): result_next.out_byte = head_id[15:8];
                        OFF_W'(2): result_next.out_byte = head_len;
                        default:   result_next.out_byte = byte_rdata;
                    endcase
                    if (pop_off_reg >= head_len_ext + OFF_W'(2))
                    begin
                        result_next.record_end = 1'b1;
                        pop_off_next = '0;
                        head_next    = (head_reg == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                       '0 : head_reg + SLOT_W'(1);
                        count_next   = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        pop_off_next = pop_off_reg + OFF_W'(1);
                    end
                end
            end
            result_next.queue_count = count_ext[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            push_len_reg     <= '0;
            drop_reg         <= tsf_pkg::DROP_NONE;
            pop_off_reg      <= '0;
            enable_reg       <= '0;
            for (int k = 0; k < tsf_pkg::SLOT_MAX; k++)
            begin
                cfg_id_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            push_len_reg     <= push_len_next;
            drop_reg         <= drop_next;
            pop_off_reg      <= pop_off_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index < tsf_pkg::CFG_ENABLE_MASK)
                begin
                    cfg_id_reg[cfg_index] <= cfg_data;
                end
                else if (cfg_index == tsf_pkg::CFG_ENABLE_MASK)
                begin
                    enable_reg <= cfg_data[tsf_pkg::SLOT_MAX-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        result_reg  <= result_next;
        push_id_reg <= push_id_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/tsf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsf_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire tsf_pkg::result_t result
);

    // status code in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status <= tsf_pkg::ST_EMPTY))
        else $error("status code out of range");

    // record end only on a delivered pop byte
    a_end_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.record_end |-> result.status == tsf_pkg::ST_OK)
        else $error("record end without pop byte");

    // no data on answers other than a delivered pop byte
    a_quiet_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != tsf_pkg::ST_OK)
            |-> (result.out_byte == '0) && !result.record_end)
        else $error("byte driven on non-pop status");

    // stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    // an accepted word stalls the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("word accepted back to back");

endmodule

bind tagged_record_stream_fifo tsf_checker u_tsf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import tsf_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int QDEPTH      = 64;
    localparam int MAX_PAY     = 255;
    localparam int ITEM_TARGET = 1300;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_ID_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = 3'd7;

    typedef struct packed {
        item_t   w;
        logic    checked;
        result_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t in_word = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t out_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [ID_W-1:0] stream_ids [SLOT_MAX];
    logic [5:0] stream_mask = '0;
    logic [ID_W-1:0] ring_ids [QDEPTH];
    logic [7:0] ring_lens [QDEPTH];
    logic [7:0] ring_bytes [QDEPTH*256];
    logic [5:0] ring_head = '0;
    logic [5:0] ring_tail = '0;
    logic [6:0] ring_count = '0;
    logic [8:0] wr_len = '0;
    logic [STATUS_W-1:0] wr_drop = DROP_NONE;
    logic [8:0] rd_pos = '0;

    // record being generated
    int rec_left = 0;
    logic [ID_W-1:0] rec_id = '0;
    bit rec_first = 1'b0;
    bit short_recs = 1'b0;

    result_t awaited_responses [$];
    plan_row_t dir_rows [$];
    int words_sent = 0;
    int errors = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_off_req = 1'b0;

    tagged_record_stream_fifo #(
        .QUEUE_DEPTH(QDEPTH),
        .MAX_PAYLOAD(MAX_PAY),
        .STREAM_SLOTS(SLOT_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(in_word),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(out_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic bit stream_enabled(input logic [ID_W-1:0] id);
        for (int k = 0; k < SLOT_MAX; k++)
        begin
            if (stream_mask[k] && stream_ids[k] == id)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void ring_set_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        if (idx < SLOT_MAX)
            stream_ids[idx] = val;
        else if (idx == CFG_ENABLE_MASK)
            stream_mask = val[5:0];
    endfunction

    function automatic result_t ring_response(input item_t w);
        result_t r;
        logic [7:0] len;
        logic [7:0] off;
        r = '0;
        if (w.operation == OP_PUSH)
        begin
            if (wr_drop == DROP_NONE)
            begin
                if (wr_len == 0)
                begin
                    if (!stream_enabled(w.stream_id))
                        wr_drop = ST_DISABLED;
                    else if (ring_count >= QDEPTH)
                        wr_drop = ST_FULL;
                    else
                        ring_ids[ring_tail] = w.stream_id;
                end
                else if (wr_len >= MAX_PAY)
                begin
                    wr_drop = ST_TOO_LONG;
                end
            end
            if (wr_drop != DROP_NONE)
            begin
                r.status = wr_drop;
                if (w.last_byte)
                begin
                    wr_drop = DROP_NONE;
                    wr_len = '0;
                end
            end
            else
            begin
                ring_bytes[{ring_tail, wr_len[7:0]}] = w.data_byte;
                wr_len++;
                if (w.last_byte)
                begin
                    ring_lens[ring_tail] = wr_len[7:0];
                    ring_tail++;
                    ring_count++;
                    wr_len = '0;
                end
                r.status = ST_STORED;
            end
        end
        else
        begin
            if (ring_count == 0)
                r.status = ST_EMPTY;
            else
            begin
                len = ring_lens[ring_head];
                if (rd_pos == 0 && HDR_BYTES + len > w.frame_room)
                    r.status = ST_EMPTY;
                else
                begin
                    r.status = ST_OK;
                    off = 8'(rd_pos - 9'(HDR_BYTES));
                    if (rd_pos == 0)
                        r.out_byte = ring_ids[ring_head][7:0];
                    else if (rd_pos == 1)
                        r.out_byte = ring_ids[ring_head][15:8];
                    else if (rd_pos == HDR_BYTES - 1)
                        r.out_byte = len;
                    else
                        r.out_byte = ring_bytes[{ring_head, off}];
                    if (rd_pos >= HDR_BYTES - 1 + len)
                    begin
                        r.record_end = 1'b1;
                        rd_pos = '0;
                        ring_head++;
                        ring_count--;
                    end
                    else
                    begin
                        rd_pos++;
                    end
                end
            end
        end
        r.queue_count = ring_count;
        return r;
    endfunction

    function automatic item_t next_word(input bit want_pop);
        item_t w;
        logic [63:0] noise;
        logic [7:0] head_len;
        int pick;
        noise = {$urandom, $urandom};
        w = noise[$bits(item_t)-1:0];
        if (want_pop)
        begin
            w.operation = OP_POP;
            if (rd_pos == 0 && ring_count != 0)
            begin
                head_len = ring_lens[ring_head];
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    w.frame_room = ROOM_W'(HDR_BYTES + head_len + $urandom_range(0, 2));
                else if (pick == 7)
                    w.frame_room = ROOM_W'(HDR_BYTES + head_len - 1);
            end
        end
        else
        begin
            w.operation = OP_PUSH;
            if (rec_left == 0)
            begin
                pick = $urandom_range(0, 99);
                if (short_recs)
                    rec_left = $urandom_range(1, 2);
                else if (pick < 70)
                    rec_left = $urandom_range(1, 8);
                else if (pick < 90)
                    rec_left = $urandom_range(9, 40);
                else if (pick < 97)
                    rec_left = $urandom_range(41, MAX_PAY - 1);
                else if (pick < 99)
                    rec_left = MAX_PAY;
                else
                    rec_left = $urandom_range(MAX_PAY + 1, MAX_PAY + 3);
                if ($urandom_range(0, 99) < 85)
                    rec_id = stream_ids[$urandom_range(0, SLOT_MAX - 1)];
                else
                    rec_id = ID_W'($urandom);
                rec_first = 1'b1;
            end
            if (rec_first)
                w.stream_id = rec_id;
            rec_first = 1'b0;
            w.last_byte = (rec_left == 1);
            rec_left--;
        end
        return w;
    endfunction

    function automatic logic [SLOT_MAX*ID_W-1:0] rand_ids();
        logic [SLOT_MAX*ID_W-1:0] ids;
        int pick;
        for (int k = 0; k < SLOT_MAX; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                ids[ID_W*k +: ID_W] = '0;
            else if (pick == 1)
                ids[ID_W*k +: ID_W] = '1;
            else
                ids[ID_W*k +: ID_W] = ID_W'($urandom);
        end
        return ids;
    endfunction

    function automatic void table_row(input logic op, input logic [ID_W-1:0] id,
                                      input logic [7:0] data, input logic last,
                                      input logic [ROOM_W-1:0] room, input logic chk,
                                      input logic [STATUS_W-1:0] st,
                                      input logic [7:0] ob, input logic rend,
                                      input logic [6:0] qc);
        plan_row_t row;
        row.w.operation = op;
        row.w.stream_id = id;
        row.w.data_byte = data;
        row.w.last_byte = last;
        row.w.frame_room = room;
        row.checked = chk;
        row.want.status = st;
        row.want.out_byte = ob;
        row.want.record_end = rend;
        row.want.queue_count = qc;
        dir_rows.push_back(row);
    endfunction

    task automatic send_word(input item_t w, input logic typed, input result_t want);
        result_t predicted;
        in_word <= w;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        predicted = ring_response(w);
        awaited_responses.push_back(typed ? want : predicted);
        words_sent++;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            item_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        ring_set_reg(idx, val);
    endtask

    task automatic program_streams(input logic [SLOT_MAX*ID_W-1:0] ids,
                                   input logic [5:0] mask);
        logic [CFG_DATA_W-1:0] mask_word;
        for (int k = 0; k < SLOT_MAX; k++)
            write_reg(CFG_STREAM_ID_A + CFG_IDX_W'(k), ids[ID_W*k +: ID_W]);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        mask_word = CFG_DATA_W'($urandom);
        mask_word[5:0] = mask;
        write_reg(CFG_ENABLE_MASK, mask_word);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic run_mixed(input int words, input int pop_pct);
        repeat (words)
            send_word(next_word($urandom_range(0, 99) < pop_pct), 1'b0, '0);
    endtask

    task automatic force_record(input int len);
        rec_left = len;
        rec_id = stream_ids[0];
        rec_first = 1'b1;
        while (rec_left != 0)
            send_word(next_word(1'b0), 1'b0, '0);
    endtask

    always
    begin : result_sink
        @(posedge clk);
        if (hold_off_req)
        begin
            result_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off_req = 1'b0;
            result_stall <= 1'b0;
        end
        else if ($urandom_range(0, 99) < sink_stall_pct)
        begin
            result_stall <= 1'b1;
            repeat (gap_len()) @(posedge clk);
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_responses.size() == 0)
            begin
                errors++;
                if (errors <= 30)
                    $display("%0t: unexpected word st=%0d byte=%02h end=%0b cnt=%0d", $time,
                             out_word.status, out_word.out_byte, out_word.record_end,
                             out_word.queue_count);
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (out_word.status !== want.status || out_word.out_byte !== want.out_byte ||
                    out_word.record_end !== want.record_end ||
                    out_word.queue_count !== want.queue_count)
                begin
                    errors++;
                    if (errors <= 30)
                        $display({"%0t: mismatch expected st=%0d byte=%02h end=%0b cnt=%0d,",
                                  " actual st=%0d byte=%02h end=%0b cnt=%0d"}, $time,
                                 want.status, want.out_byte, want.record_end,
                                 want.queue_count, out_word.status, out_word.out_byte,
                                 out_word.record_end, out_word.queue_count);
                end
            end
        end
    end

    initial
    begin
        for (int k = 0; k < SLOT_MAX; k++)
            stream_ids[k] = '0;

        // slot 2 (id 1234) disabled
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'hFFFF, 1, ST_EMPTY,    8'h00, 0, 0);
        table_row(OP_PUSH, 16'h1234, 8'h00, 1'b0, 16'h0000, 1, ST_DISABLED, 8'h00, 0, 0);
        table_row(OP_PUSH, 16'h0000, 8'hFF, 1'b1, 16'hFFFF, 1, ST_DISABLED, 8'h00, 0, 0);
        table_row(OP_PUSH, 16'h0000, 8'hFF, 1'b1, 16'h0000, 1, ST_STORED,   8'h00, 0, 1);
        table_row(OP_PUSH, 16'hFFFF, 8'h00, 1'b0, 16'h0000, 1, ST_STORED,   8'h00, 0, 1);
        table_row(OP_PUSH, 16'h5555, 8'hAA, 1'b1, 16'h0000, 1, ST_STORED,   8'h00, 0, 2);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd3,    1, ST_EMPTY,    8'h00, 0, 2);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd4,    1, ST_OK,       8'h00, 0, 2);
        table_row(OP_POP,  16'hFFFF, 8'hFF, 1'b1, 16'd0,    1, ST_OK,       8'h00, 0, 2);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd0,    1, ST_OK,       8'h01, 0, 2);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd0,    1, ST_OK,       8'hFF, 1, 1);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'hFFFF, 1, ST_OK,       8'hFF, 0, 1);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd0,    1, ST_OK,       8'hFF, 0, 1);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd0,    1, ST_OK,       8'h02, 0, 1);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd0,    1, ST_OK,       8'h00, 0, 1);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd0,    1, ST_OK,       8'hAA, 1, 0);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd0,    1, ST_EMPTY,    8'h00, 0, 0);
        table_row(OP_PUSH, 16'hFF00, 8'h81, 1'b1, 16'h0000, 0, ST_OK,       8'h00, 0, 0);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd4,    0, ST_OK,       8'h00, 0, 0);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd0,    0, ST_OK,       8'h00, 0, 0);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd0,    0, ST_OK,       8'h00, 0, 0);
        table_row(OP_POP,  16'h0000, 8'h00, 1'b0, 16'd0,    0, ST_OK,       8'h00, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_streams({16'hFF00, 16'h00FF, 16'hA5C3, 16'h1234, 16'hFFFF, 16'h0000},
                        6'b111011);
        src_idle_pct = 25;
        sink_stall_pct = 25;
        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].checked, dir_rows[i].want);
        drain_results();

        // longest record, then one byte too many
        program_streams(rand_ids(), 6'h3F);
        src_idle_pct = 30;
        sink_stall_pct = 30;
        force_record(MAX_PAY);
        while (ring_count != 0)
            send_word(next_word(1'b1), 1'b0, '0);
        force_record(MAX_PAY + 1);
        run_mixed(40, 50);
        drain_results();

        // receiver holds off while words keep coming, then sender waits it out
        program_streams(rand_ids(), 6'($urandom_range(0, 63)));
        src_idle_pct = 20;
        sink_stall_pct = 20;
        hold_off_req = 1'b1;
        run_mixed(60, 45);
        drain_results();
        run_mixed(60, 55);
        drain_results();

        // fill to full with short records, overflow, then drain, no idling
        program_streams(rand_ids(), 6'h3F);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        short_recs = 1'b1;
        while (ring_count < QDEPTH)
            send_word(next_word(1'b0), 1'b0, '0);
        repeat (12)
            send_word(next_word(1'b0), 1'b0, '0);
        while (rec_left != 0)
            send_word(next_word(1'b0), 1'b0, '0);
        while (ring_count != 0 || rd_pos != 0)
            send_word(next_word(1'b1), 1'b0, '0);
        short_recs = 1'b0;
        drain_results();

        // every stream disabled
        program_streams(rand_ids(), 6'h00);
        src_idle_pct = 40;
        sink_stall_pct = 40;
        run_mixed(40, 50);
        drain_results();

        while (words_sent < ITEM_TARGET)
        begin
            program_streams(rand_ids(), 6'($urandom_range(0, 63)));
            src_idle_pct = $urandom_range(0, 50);
            sink_stall_pct = $urandom_range(0, 50);
            run_mixed((ITEM_TARGET - words_sent > 150) ? 150 : ITEM_TARGET - words_sent,
                      $urandom_range(30, 70));
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
